/* hw/rtl/bcai_pkg.sv */
// Shared types, codes and constants for the byte-driven ADC subset processor core.
package bcai_pkg;

  // Default width of the emulated cycle counter.
  localparam int unsigned CycleBitsDefault = 32;

  // Command codes carried with each input word.
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_RESET = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Reset vector addresses.
  localparam logic [15:0] VEC_LO_ADDR = 16'hFFFC;
  localparam logic [15:0] VEC_HI_ADDR = 16'hFFFD;

  // Register reset values.
  localparam logic [7:0] FLAGS_RESET = 8'h20;
  localparam logic [7:0] SP_RESET    = 8'hFD;
  localparam logic [7:0] SP_WARM_DEC = 8'h03;

  // Status flag bit positions.
  localparam int unsigned FL_C = 0;
  localparam int unsigned FL_Z = 1;
  localparam int unsigned FL_V = 6;
  localparam int unsigned FL_N = 7;

  // Supported opcodes.
  localparam logic [7:0] OP_ADC_IMM = 8'h69;
  localparam logic [7:0] OP_ADC_ZP  = 8'h65;
  localparam logic [7:0] OP_ADC_ZPX = 8'h75;
  localparam logic [7:0] OP_ADC_IZX = 8'h61;
  localparam logic [7:0] OP_ADC_IZY = 8'h71;
  localparam logic [7:0] OP_ADC_ABS = 8'h6D;
  localparam logic [7:0] OP_ADC_ABX = 8'h7D;
  localparam logic [7:0] OP_ADC_ABY = 8'h79;
  localparam logic [7:0] OP_INX     = 8'hE8;
  localparam logic [7:0] OP_INY     = 8'hC8;
  localparam logic [7:0] OP_NOP     = 8'hEA;

  // Bus sequencer steps.
  typedef enum logic [3:0] {
    SEQ_VLO   = 4'd0,
    SEQ_VHI   = 4'd1,
    SEQ_FETCH = 4'd2,
    SEQ_IMM   = 4'd3,
    SEQ_ZP    = 4'd4,
    SEQ_PLO   = 4'd5,
    SEQ_PHI   = 4'd6,
    SEQ_ALO   = 4'd7,
    SEQ_AHI   = 4'd8,
    SEQ_DATA  = 4'd9
  } seq_e;

  // Architectural and sequencer state, apart from the cycle counter.
  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  flags;
    logic [7:0]  sp;
    seq_e        seq;
    logic [7:0]  opcode;
    logic [7:0]  operand_lo;
    logic [7:0]  operand_hi;
    logic [7:0]  pointer;
    logic        halt;
    logic [15:0] next_addr;
  } core_state_t;

  localparam core_state_t STATE_RESET = '{
    pc:         16'h0000,
    acc:        8'h00,
    x:          8'h00,
    y:          8'h00,
    flags:      FLAGS_RESET,
    sp:         SP_RESET,
    seq:        SEQ_VLO,
    opcode:     8'h00,
    operand_lo: 8'h00,
    operand_hi: 8'h00,
    pointer:    8'h00,
    halt:       1'b0,
    next_addr:  VEC_LO_ADDR
  };

  // Input word.
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] read_data;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [15:0] read_address;
    logic [7:0]  acc;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  status_flags;
    logic [7:0]  stack_pointer;
    logic [15:0] program_counter;
    logic [31:0] cycle_count;
    logic        instr_done;
    logic        halted;
  } out_word_t;

endpackage

/* hw/rtl/bcai_step.sv */
// Next-state logic of the processor core for one bus word.
module bcai_step (
  input  bcai_pkg::in_word_t    in_word_i,
  input  bcai_pkg::core_state_t state_i,
  output bcai_pkg::core_state_t state_o,
  output logic [1:0]            cycle_inc_o,
  output logic                  instr_done_o
);

  // Update N and Z from a result byte, keeping the other flags.
  function automatic logic [7:0] set_nz(input logic [7:0] flags, input logic [7:0] v);
    logic [7:0] f;
    f = flags;
    f[bcai_pkg::FL_Z] = (v == 8'h00);
    f[bcai_pkg::FL_N] = v[7];
    return f;
  endfunction

  // Binary add with carry; returns the new flags above the new accumulator.
  function automatic logic [15:0] adc(input logic [7:0] acc, input logic [7:0] flags,
                                      input logic [7:0] v);
    logic [8:0] sum;
    logic [7:0] t;
    logic [7:0] f;
    sum = {1'b0, acc} + {1'b0, v} + {8'h00, flags[bcai_pkg::FL_C]};
    t = sum[7:0];
    f = flags;
    f[bcai_pkg::FL_C] = sum[8];
    f[bcai_pkg::FL_V] = (t[7] ^ acc[7]) & (t[7] ^ v[7]);
    f = set_nz(f, t);
    return {f, t};
  endfunction

  logic [7:0]  rd;
  logic [15:0] pc_inc;
  logic [15:0] adc_res;
  logic [15:0] base_addr;
  logic [7:0]  index_sel;
  logic [7:0]  x_inc;
  logic [7:0]  y_inc;
  logic        cross_x;
  logic        cross_y;

  assign rd      = in_word_i.read_data;
  assign pc_inc  = state_i.pc + 16'd1;
  assign adc_res = adc(state_i.acc, state_i.flags, rd);
  assign x_inc   = state_i.x + 8'd1;
  assign y_inc   = state_i.y + 8'd1;

  // Page crossing of the base low byte plus an index register.
  assign cross_x = 9'({1'b0, state_i.operand_lo} + {1'b0, state_i.x}) > 9'h0FF;
  assign cross_y = 9'({1'b0, state_i.operand_lo} + {1'b0, state_i.y}) > 9'h0FF;

  // Index added to a fetched absolute or indirect base address.
  always_comb begin
    case (state_i.opcode)
      bcai_pkg::OP_ADC_ABX: index_sel = state_i.x;
      bcai_pkg::OP_ADC_ABY,
      bcai_pkg::OP_ADC_IZY: index_sel = state_i.y;
      default:              index_sel = 8'h00;
    endcase
    base_addr = {rd, state_i.operand_lo} + {8'h00, index_sel};
  end

  // One sequencer step for the incoming word.
  always_comb begin
    state_o      = state_i;
    cycle_inc_o  = 2'd0;
    instr_done_o = 1'b0;
    case (in_word_i.func)
      bcai_pkg::FUNC_START: begin
        state_o.acc       = 8'h00;
        state_o.x         = 8'h00;
        state_o.y         = 8'h00;
        state_o.flags     = bcai_pkg::FLAGS_RESET;
        state_o.sp        = bcai_pkg::SP_RESET;
        state_o.halt      = 1'b0;
        state_o.seq       = bcai_pkg::SEQ_VLO;
        state_o.next_addr = bcai_pkg::VEC_LO_ADDR;
      end
      bcai_pkg::FUNC_RESET: begin
        state_o.sp        = state_i.sp - bcai_pkg::SP_WARM_DEC;
        state_o.halt      = 1'b0;
        state_o.seq       = bcai_pkg::SEQ_VLO;
        state_o.next_addr = bcai_pkg::VEC_LO_ADDR;
      end
      bcai_pkg::FUNC_READ: begin
        if (!state_i.halt) begin
          cycle_inc_o = 2'd1;
          case (state_i.seq)
            bcai_pkg::SEQ_VLO: begin
              state_o.operand_lo = rd;
              state_o.seq        = bcai_pkg::SEQ_VHI;
              state_o.next_addr  = bcai_pkg::VEC_HI_ADDR;
            end
            bcai_pkg::SEQ_VHI: begin
              state_o.operand_hi = rd;
              state_o.pc         = {rd, state_i.operand_lo};
              state_o.seq        = bcai_pkg::SEQ_FETCH;
              state_o.next_addr  = {rd, state_i.operand_lo};
              instr_done_o       = 1'b1;
            end
            bcai_pkg::SEQ_FETCH: begin
              state_o.opcode    = rd;
              state_o.pc        = pc_inc;
              state_o.next_addr = pc_inc;
              case (rd)
                bcai_pkg::OP_ADC_IMM: state_o.seq = bcai_pkg::SEQ_IMM;
                bcai_pkg::OP_ADC_ZP,
                bcai_pkg::OP_ADC_ZPX,
                bcai_pkg::OP_ADC_IZX,
                bcai_pkg::OP_ADC_IZY: state_o.seq = bcai_pkg::SEQ_ZP;
                bcai_pkg::OP_ADC_ABS,
                bcai_pkg::OP_ADC_ABX,
                bcai_pkg::OP_ADC_ABY: state_o.seq = bcai_pkg::SEQ_ALO;
                bcai_pkg::OP_INX: begin
                  state_o.x     = x_inc;
                  state_o.flags = set_nz(state_i.flags, x_inc);
                  cycle_inc_o   = 2'd2;
                  state_o.seq   = bcai_pkg::SEQ_FETCH;
                  instr_done_o  = 1'b1;
                end
                bcai_pkg::OP_INY: begin
                  state_o.y     = y_inc;
                  state_o.flags = set_nz(state_i.flags, y_inc);
                  cycle_inc_o   = 2'd2;
                  state_o.seq   = bcai_pkg::SEQ_FETCH;
                  instr_done_o  = 1'b1;
                end
                bcai_pkg::OP_NOP: begin
                  cycle_inc_o  = 2'd2;
                  state_o.seq  = bcai_pkg::SEQ_FETCH;
                  instr_done_o = 1'b1;
                end
                default: begin
                  // Unsupported opcode: stop until the next start or reset.
                  state_o.halt      = 1'b1;
                  state_o.seq       = bcai_pkg::SEQ_FETCH;
                  state_o.next_addr = 16'h0000;
                end
              endcase
            end
            bcai_pkg::SEQ_IMM: begin
              state_o.pc        = pc_inc;
              state_o.flags     = adc_res[15:8];
              state_o.acc       = adc_res[7:0];
              state_o.seq       = bcai_pkg::SEQ_FETCH;
              state_o.next_addr = pc_inc;
              instr_done_o      = 1'b1;
            end
            bcai_pkg::SEQ_ZP: begin
              state_o.pc = pc_inc;
              if (state_i.opcode == bcai_pkg::OP_ADC_IZX ||
                  state_i.opcode == bcai_pkg::OP_ADC_IZY) begin
                state_o.pointer = (state_i.opcode == bcai_pkg::OP_ADC_IZX) ?
                                  rd + state_i.x : rd;
                state_o.seq       = bcai_pkg::SEQ_PLO;
                state_o.next_addr = {8'h00, state_o.pointer};
              end else begin
                state_o.seq       = bcai_pkg::SEQ_DATA;
                state_o.next_addr = (state_i.opcode == bcai_pkg::OP_ADC_ZPX) ?
                                    {8'h00, 8'(rd + state_i.x)} : {8'h00, rd};
              end
            end
            bcai_pkg::SEQ_PLO: begin
              state_o.operand_lo = rd;
              state_o.pointer    = state_i.pointer + 8'd1;
              state_o.seq        = bcai_pkg::SEQ_PHI;
              state_o.next_addr  = {8'h00, 8'(state_i.pointer + 8'd1)};
            end
            bcai_pkg::SEQ_PHI: begin
              state_o.operand_hi = rd;
              state_o.next_addr  = base_addr;
              state_o.seq        = bcai_pkg::SEQ_DATA;
            end
            bcai_pkg::SEQ_ALO: begin
              state_o.pc         = pc_inc;
              state_o.operand_lo = rd;
              state_o.seq        = bcai_pkg::SEQ_AHI;
              state_o.next_addr  = pc_inc;
            end
            bcai_pkg::SEQ_AHI: begin
              state_o.pc         = pc_inc;
              state_o.operand_hi = rd;
              state_o.next_addr  = base_addr;
              state_o.seq        = bcai_pkg::SEQ_DATA;
            end
            default: begin
              // Operand data step, also taken by unused sequencer codes.
              if (state_i.opcode == bcai_pkg::OP_ADC_ZPX ||
                  state_i.opcode == bcai_pkg::OP_ADC_IZX ||
                  (state_i.opcode == bcai_pkg::OP_ADC_ABX && cross_x) ||
                  ((state_i.opcode == bcai_pkg::OP_ADC_ABY ||
                    state_i.opcode == bcai_pkg::OP_ADC_IZY) && cross_y)) begin
                cycle_inc_o = 2'd2;
              end
              state_o.flags     = adc_res[15:8];
              state_o.acc       = adc_res[7:0];
              state_o.seq       = bcai_pkg::SEQ_FETCH;
              state_o.next_addr = state_i.pc;
              instr_done_o      = 1'b1;
            end
          endcase
        end
      end
      default: begin
        // Unused command: state is reported unchanged.
      end
    endcase
  end

endmodule

/* hw/rtl/byte_cpu_adc_index_core.sv */
// Top level of the byte-driven ADC subset processor core.
//
// The core is fed one word per bus event on the input channel (valid/ready):
// a power-up start, a warm reset, or the byte read back from the address
// the core last asked for. For every input word it returns exactly one
// result word on the output channel (valid/ready) carrying the next read
// address, all registers, the low 32 bits of the cycle counter, an
// instruction-complete flag and a halted flag.
// A word accepted into the input register passes through the combinational
// step logic into the result register.
// Throughput: one word per cycle while the receiver takes results; the step
// logic between the two registers is combinational 8-bit and 16-bit adds.
// The input register takes a new word whenever it is empty, or when its word
// moves on in the same cycle because the result register is empty or taken;
// when the receiver stalls, the result holds, the input register fills and
// ready drops until the receiver takes the waiting word.
// Reset clears both channels and puts the core into the reset vector fetch,
// awaiting the byte at the vector low address, with the cycle counter zero.
module byte_cpu_adc_index_core #(
  parameter int unsigned CYCLE_BITS = bcai_pkg::CycleBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bcai_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bcai_pkg::out_word_t out_word_o
);

  logic                  in_valid_q;
  bcai_pkg::in_word_t    in_word_q;
  logic                  out_valid_q;
  bcai_pkg::out_word_t   out_word_q;
  bcai_pkg::out_word_t   out_word_d;
  bcai_pkg::core_state_t state_q;
  bcai_pkg::core_state_t state_d;
  logic [CYCLE_BITS-1:0] cycle_q;
  logic [CYCLE_BITS-1:0] cycle_d;
  logic [1:0]            cycle_inc;
  logic                  instr_done;
  logic                  advance;
  logic                  fire;

  // Handshake: the result register moves when empty or being taken.
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_word_q <= in_word_i;
    end
  end

  // Step logic for the registered word.
  bcai_step u_step (
    .in_word_i    (in_word_q),
    .state_i      (state_q),
    .state_o      (state_d),
    .cycle_inc_o  (cycle_inc),
    .instr_done_o (instr_done)
  );

  assign cycle_d = cycle_q + CYCLE_BITS'(cycle_inc);

  // Core state and cycle counter advance once per processed word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcai_pkg::STATE_RESET;
      cycle_q <= '0;
    end else if (fire) begin
      state_q <= state_d;
      cycle_q <= cycle_d;
    end
  end

  // Assemble the result word from the updated state.
  always_comb begin
    out_word_d.read_address    = state_d.halt ? 16'h0000 : state_d.next_addr;
    out_word_d.acc             = state_d.acc;
    out_word_d.index_x         = state_d.x;
    out_word_d.index_y         = state_d.y;
    out_word_d.status_flags    = state_d.flags;
    out_word_d.stack_pointer   = state_d.sp;
    out_word_d.program_counter = state_d.pc;
    out_word_d.cycle_count     = 32'(cycle_d);
    out_word_d.instr_done      = instr_done;
    out_word_d.halted          = state_d.halt;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* hw/rtl/bcai_checker.sv */
// Port-level checks for the processor core, bound to the top level.
module bcai_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input bcai_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input bcai_pkg::out_word_t out_word_o
);

  // A stalled result word holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // A halted core requests no bus reads.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.halted |-> out_word_o.read_address == 16'h0000)
    else $error("halted core reports a read address");

  // A completed instruction leaves the core fetching at the program counter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.instr_done |->
      !out_word_o.halted && out_word_o.read_address == out_word_o.program_counter)
    else $error("completed instruction does not fetch at the program counter");

  // The unused status bit stays set and the unmodelled bits stay clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.status_flags[5] && out_word_o.status_flags[4:2] == 3'b000)
    else $error("status byte has an impossible bit pattern");

  // With the output stalled and the input register full, no word is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && in_valid_i && in_ready_o |=> !in_ready_o || !out_valid_o
      || out_ready_i || $past(out_ready_i))
    else $error("input taken with no room behind a stalled result");

endmodule

bind byte_cpu_adc_index_core bcai_checker u_bcai_checker (.*);

/* bench/bcai_core_checker.sv */
// Checker for the byte-driven ADC subset core: predicts each result word and compares it.
module bcai_core_checker #(
  parameter int unsigned CYCLE_BITS = bcai_pkg::CycleBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  bcai_pkg::in_word_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  bcai_pkg::out_word_t out_word_i,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o,
  output int unsigned         results_o,
  output int unsigned         retired_o,
  output int unsigned         halts_o
);

  // Predicted processor state and its own cycle counter.
  bcai_pkg::core_state_t cpu;
  logic [CYCLE_BITS-1:0] cpu_cycles;

  // Result words predicted but not yet seen on the output channel.
  bcai_pkg::out_word_t awaited_results[$];
  int unsigned         bad_fields;
  int unsigned         checked;
  int unsigned         retired;
  int unsigned         halts;

  function automatic void set_nz(input logic [7:0] v);
    cpu.flags[bcai_pkg::FL_Z] = (v == 8'h00);
    cpu.flags[bcai_pkg::FL_N] = v[7];
  endfunction

  // Binary add with carry; overflow when both operands differ in sign from the sum.
  function automatic void add_to_acc(input logic [7:0] v);
    logic [8:0] sum;
    logic [7:0] t;
    sum = {1'b0, cpu.acc} + {1'b0, v} + {8'h00, cpu.flags[bcai_pkg::FL_C]};
    t = sum[7:0];
    cpu.flags[bcai_pkg::FL_C] = sum[8];
    cpu.flags[bcai_pkg::FL_V] = (((t ^ cpu.acc) & (t ^ v) & 8'h80) != 8'h00);
    set_nz(t);
    cpu.acc = t;
  endfunction

  function automatic logic crosses_page(input logic [7:0] lo, input logic [7:0] idx);
    logic [8:0] s;
    s = {1'b0, lo} + {1'b0, idx};
    return s[8];
  endfunction

  function automatic void start_vector();
    cpu.halt = 1'b0;
    cpu.seq = bcai_pkg::SEQ_VLO;
    cpu.next_addr = bcai_pkg::VEC_LO_ADDR;
  endfunction

  // One bus byte through the sequencer; returns whether an instruction finished.
  function automatic logic take_byte(input logic [7:0] d);
    logic [7:0] op;
    logic [7:0] zp;
    logic       fin;
    op = cpu.opcode;
    fin = 1'b0;
    cpu_cycles = cpu_cycles + 1'b1;
    case (cpu.seq)
      bcai_pkg::SEQ_VLO: begin
        cpu.operand_lo = d;
        cpu.seq = bcai_pkg::SEQ_VHI;
        cpu.next_addr = bcai_pkg::VEC_HI_ADDR;
      end
      bcai_pkg::SEQ_VHI: begin
        cpu.operand_hi = d;
        cpu.pc = {d, cpu.operand_lo};
        fin = 1'b1;
      end
      bcai_pkg::SEQ_FETCH: begin
        cpu.opcode = d;
        cpu.pc = cpu.pc + 16'd1;
        case (d)
          bcai_pkg::OP_ADC_IMM: begin
            cpu.seq = bcai_pkg::SEQ_IMM;
            cpu.next_addr = cpu.pc;
          end
          bcai_pkg::OP_ADC_ZP, bcai_pkg::OP_ADC_ZPX,
          bcai_pkg::OP_ADC_IZX, bcai_pkg::OP_ADC_IZY: begin
            cpu.seq = bcai_pkg::SEQ_ZP;
            cpu.next_addr = cpu.pc;
          end
          bcai_pkg::OP_ADC_ABS, bcai_pkg::OP_ADC_ABX, bcai_pkg::OP_ADC_ABY: begin
            cpu.seq = bcai_pkg::SEQ_ALO;
            cpu.next_addr = cpu.pc;
          end
          bcai_pkg::OP_INX: begin
            cpu.x = cpu.x + 8'd1;
            set_nz(cpu.x);
            cpu_cycles = cpu_cycles + 1'b1;
            fin = 1'b1;
          end
          bcai_pkg::OP_INY: begin
            cpu.y = cpu.y + 8'd1;
            set_nz(cpu.y);
            cpu_cycles = cpu_cycles + 1'b1;
            fin = 1'b1;
          end
          bcai_pkg::OP_NOP: begin
            cpu_cycles = cpu_cycles + 1'b1;
            fin = 1'b1;
          end
          default: begin
            // Unsupported opcode: the core stops and reads nothing further.
            cpu.halt = 1'b1;
            cpu.seq = bcai_pkg::SEQ_FETCH;
            cpu.next_addr = 16'h0000;
            halts++;
          end
        endcase
      end
      bcai_pkg::SEQ_IMM: begin
        cpu.pc = cpu.pc + 16'd1;
        add_to_acc(d);
        fin = 1'b1;
      end
      bcai_pkg::SEQ_ZP: begin
        cpu.pc = cpu.pc + 16'd1;
        // Zero-page sums wrap within page zero.
        zp = (op == bcai_pkg::OP_ADC_ZPX || op == bcai_pkg::OP_ADC_IZX) ? d + cpu.x : d;
        if (op == bcai_pkg::OP_ADC_IZX || op == bcai_pkg::OP_ADC_IZY) begin
          cpu.pointer = zp;
          cpu.seq = bcai_pkg::SEQ_PLO;
        end else begin
          cpu.seq = bcai_pkg::SEQ_DATA;
        end
        cpu.next_addr = {8'h00, zp};
      end
      bcai_pkg::SEQ_PLO: begin
        cpu.operand_lo = d;
        cpu.pointer = cpu.pointer + 8'd1;
        cpu.seq = bcai_pkg::SEQ_PHI;
        cpu.next_addr = {8'h00, cpu.pointer};
      end
      bcai_pkg::SEQ_PHI: begin
        cpu.operand_hi = d;
        cpu.next_addr = {d, cpu.operand_lo}
                        + {8'h00, (op == bcai_pkg::OP_ADC_IZY) ? cpu.y : 8'h00};
        cpu.seq = bcai_pkg::SEQ_DATA;
      end
      bcai_pkg::SEQ_ALO: begin
        cpu.pc = cpu.pc + 16'd1;
        cpu.operand_lo = d;
        cpu.seq = bcai_pkg::SEQ_AHI;
        cpu.next_addr = cpu.pc;
      end
      bcai_pkg::SEQ_AHI: begin
        cpu.pc = cpu.pc + 16'd1;
        cpu.operand_hi = d;
        if (op == bcai_pkg::OP_ADC_ABX) begin
          zp = cpu.x;
        end else if (op == bcai_pkg::OP_ADC_ABY) begin
          zp = cpu.y;
        end else begin
          zp = 8'h00;
        end
        cpu.next_addr = {d, cpu.operand_lo} + {8'h00, zp};
        cpu.seq = bcai_pkg::SEQ_DATA;
      end
      default: begin
        // Operand byte: extra cycles for indexed modes and page crossings.
        if (op == bcai_pkg::OP_ADC_ZPX || op == bcai_pkg::OP_ADC_IZX) begin
          cpu_cycles = cpu_cycles + 1'b1;
        end
        if (op == bcai_pkg::OP_ADC_ABX && crosses_page(cpu.operand_lo, cpu.x)) begin
          cpu_cycles = cpu_cycles + 1'b1;
        end
        if ((op == bcai_pkg::OP_ADC_ABY || op == bcai_pkg::OP_ADC_IZY) &&
            crosses_page(cpu.operand_lo, cpu.y)) begin
          cpu_cycles = cpu_cycles + 1'b1;
        end
        add_to_acc(d);
        fin = 1'b1;
      end
    endcase
    if (fin) begin
      cpu.seq = bcai_pkg::SEQ_FETCH;
      cpu.next_addr = cpu.pc;
    end
    return fin;
  endfunction

  // Applies one input word to the predicted core and forms the result word.
  function automatic bcai_pkg::out_word_t cpu_step(input bcai_pkg::in_word_t w);
    bcai_pkg::out_word_t r;
    logic                done;
    done = 1'b0;
    case (w.func)
      bcai_pkg::FUNC_START: begin
        cpu.acc = 8'h00;
        cpu.x = 8'h00;
        cpu.y = 8'h00;
        cpu.flags = bcai_pkg::FLAGS_RESET;
        cpu.sp = bcai_pkg::SP_RESET;
        start_vector();
      end
      bcai_pkg::FUNC_RESET: begin
        cpu.sp = cpu.sp - bcai_pkg::SP_WARM_DEC;
        start_vector();
      end
      bcai_pkg::FUNC_READ: begin
        if (!cpu.halt) done = take_byte(w.read_data);
      end
      default: ;
    endcase
    r.read_address = cpu.halt ? 16'h0000 : cpu.next_addr;
    r.acc = cpu.acc;
    r.index_x = cpu.x;
    r.index_y = cpu.y;
    r.status_flags = cpu.flags;
    r.stack_pointer = cpu.sp;
    r.program_counter = cpu.pc;
    r.cycle_count = 32'(cpu_cycles);
    r.instr_done = done;
    r.halted = cpu.halt;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      if (bad_fields < 10) begin
        $display("mismatch in result %0d, %s: expected %0h, got %0h", checked, name, want, got);
      end
      bad_fields++;
    end
  endtask

  // Compare each taken result word with the oldest prediction, then predict for the new word.
  always @(posedge clk_i or negedge rst_ni) begin
    bcai_pkg::out_word_t want;
    if (!rst_ni) begin
      awaited_results.delete();
      cpu = bcai_pkg::STATE_RESET;
      cpu_cycles = '0;
      bad_fields = 0;
      checked = 0;
      retired = 0;
      halts = 0;
      mismatches_o <= 0;
      pending_o <= 0;
      results_o <= 0;
      retired_o <= 0;
      halts_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          if (bad_fields < 10) $display("result word %0h arrived with none awaited", out_word_i);
          bad_fields++;
        end else begin
          want = awaited_results.pop_front();
          check_field("read_address", 32'(want.read_address), 32'(out_word_i.read_address));
          check_field("acc", 32'(want.acc), 32'(out_word_i.acc));
          check_field("index_x", 32'(want.index_x), 32'(out_word_i.index_x));
          check_field("index_y", 32'(want.index_y), 32'(out_word_i.index_y));
          check_field("status_flags", 32'(want.status_flags), 32'(out_word_i.status_flags));
          check_field("stack_pointer", 32'(want.stack_pointer),
                      32'(out_word_i.stack_pointer));
          check_field("program_counter", 32'(want.program_counter),
                      32'(out_word_i.program_counter));
          check_field("cycle_count", want.cycle_count, out_word_i.cycle_count);
          check_field("instr_done", 32'(want.instr_done), 32'(out_word_i.instr_done));
          check_field("halted", 32'(want.halted), 32'(out_word_i.halted));
          if (want.instr_done) retired++;
        end
        checked++;
      end
      if (in_valid_i && in_ready_i) awaited_results.push_back(cpu_step(in_word_i));
      mismatches_o <= bad_fields;
      pending_o <= awaited_results.size();
      results_o <= checked;
      retired_o <= retired;
      halts_o <= halts;
    end
  end

endmodule

/* bench/tb_byte_cpu_adc_index_core.sv */
// Testbench top for the byte-driven ADC subset core: stimulus, receiver and verdict.
module tb_byte_cpu_adc_index_core;

  localparam logic [1:0]  FuncUnused    = 2'd3;
  localparam int unsigned TargetWords   = 1000;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 10;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  bcai_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_ready;
  bcai_pkg::out_word_t out_word;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results;
  int unsigned retired;
  int unsigned halts;

  // Flags shared between the sender and the receiver, and counters for the stimulus and the watchdog.
  bit          quiet;
  bit          hold_off_req;
  int unsigned words_sent;
  int unsigned ignored_words;
  int unsigned idle_cycles;

  byte_cpu_adc_index_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  bcai_core_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_word_i   (out_word),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .results_o    (results),
    .retired_o    (retired),
    .halts_o      (halts)
  );

  // Clock with a period of ten units.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random byte weighted towards the arithmetic corners.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_opcode();
    case ($urandom_range(0, 10))
      0: return bcai_pkg::OP_ADC_IMM;
      1: return bcai_pkg::OP_ADC_ZP;
      2: return bcai_pkg::OP_ADC_ZPX;
      3: return bcai_pkg::OP_ADC_IZX;
      4: return bcai_pkg::OP_ADC_IZY;
      5: return bcai_pkg::OP_ADC_ABS;
      6: return bcai_pkg::OP_ADC_ABX;
      7: return bcai_pkg::OP_ADC_ABY;
      8: return bcai_pkg::OP_INX;
      9: return bcai_pkg::OP_INY;
      default: return bcai_pkg::OP_NOP;
    endcase
  endfunction

  // Bytes that follow the opcode; a negative count marks an opcode the core rejects.
  function automatic int operand_bytes(input logic [7:0] op);
    case (op)
      bcai_pkg::OP_ADC_IMM: return 1;
      bcai_pkg::OP_ADC_ZP, bcai_pkg::OP_ADC_ZPX: return 2;
      bcai_pkg::OP_ADC_IZX, bcai_pkg::OP_ADC_IZY: return 4;
      bcai_pkg::OP_ADC_ABS, bcai_pkg::OP_ADC_ABX, bcai_pkg::OP_ADC_ABY: return 3;
      bcai_pkg::OP_INX, bcai_pkg::OP_INY, bcai_pkg::OP_NOP: return 0;
      default: return -1;
    endcase
  endfunction

  // Offer one word, hold it until taken, then maybe leave a gap.
  task automatic send_word(input logic [1:0] func, input logic [7:0] data);
    int unsigned gap;
    in_valid <= 1'b1;
    in_word <= '{func: func, read_data: data};
    do @(posedge clk); while (!in_ready);
    words_sent++;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
  endtask

  // Start or warm reset followed by the two vector bytes.
  task automatic boot(input logic [1:0] func);
    send_word(func, pick_byte());
    send_word(bcai_pkg::FUNC_READ, pick_byte());
    send_word(bcai_pkg::FUNC_READ, pick_byte());
  endtask

  task automatic run_instr(input logic [7:0] op);
    send_word(bcai_pkg::FUNC_READ, op);
    repeat (operand_bytes(op)) send_word(bcai_pkg::FUNC_READ, pick_byte());
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (idle_len() + 1) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: directed corners, then random programs with resets and broken sequences.
  initial begin
    int unsigned round;
    int unsigned pick;
    logic [7:0]  op;
    rst_n = 1'b0;
    in_valid <= 1'b0;
    in_word <= '0;
    quiet = 1'b0;
    hold_off_req = 1'b0;
    words_sent = 0;
    ignored_words = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Vector straight after reset, close to the top so the PC wraps.
    send_word(bcai_pkg::FUNC_READ, 8'hFE);
    send_word(bcai_pkg::FUNC_READ, 8'hFF);
    // Immediate adds: a sum of 0xFF, carry out to zero, signed overflow.
    send_word(bcai_pkg::FUNC_READ, bcai_pkg::OP_ADC_IMM);
    send_word(bcai_pkg::FUNC_READ, 8'hFF);
    send_word(bcai_pkg::FUNC_READ, bcai_pkg::OP_ADC_IMM);
    send_word(bcai_pkg::FUNC_READ, 8'h01);
    send_word(bcai_pkg::FUNC_READ, bcai_pkg::OP_ADC_IMM);
    send_word(bcai_pkg::FUNC_READ, 8'h7F);
    run_instr(bcai_pkg::OP_INX);
    run_instr(bcai_pkg::OP_INY);
    run_instr(bcai_pkg::OP_NOP);
    // Indexed pointer wrapping within page zero.
    send_word(bcai_pkg::FUNC_READ, bcai_pkg::OP_ADC_IZX);
    send_word(bcai_pkg::FUNC_READ, 8'hFF);
    send_word(bcai_pkg::FUNC_READ, 8'h34);
    send_word(bcai_pkg::FUNC_READ, 8'h12);
    send_word(bcai_pkg::FUNC_READ, 8'h80);
    // Indirect indexed with pointer wrap and an address wrapping past 0xFFFF.
    send_word(bcai_pkg::FUNC_READ, bcai_pkg::OP_ADC_IZY);
    send_word(bcai_pkg::FUNC_READ, 8'hFF);
    send_word(bcai_pkg::FUNC_READ, 8'hFF);
    send_word(bcai_pkg::FUNC_READ, 8'hFF);
    send_word(bcai_pkg::FUNC_READ, 8'h00);
    // Unsupported opcode halts; a read byte and the unused code change nothing.
    send_word(bcai_pkg::FUNC_READ, 8'h02);
    send_word(bcai_pkg::FUNC_READ, 8'h55);
    send_word(FuncUnused, 8'hAA);
    ignored_words += 2;
    boot(bcai_pkg::FUNC_RESET);
    boot(bcai_pkg::FUNC_START);

    round = 0;
    while (words_sent - ignored_words < TargetWords) begin
      round++;
      if (round % 120 == 60) quiet = 1'b1;
      if (round % 120 == 80) quiet = 1'b0;

      if (round == 150) begin
        // Keep offering words while the receiver holds off, so the core backs up.
        quiet = 1'b1;
        hold_off_req = 1'b1;
        repeat (10) run_instr(pick_opcode());
        quiet = 1'b0;
      end else if (round == 260) begin
        // Let every outstanding result come back before carrying on.
        go_idle();
        do @(posedge clk); while (pending != 0);
      end

      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        run_instr(pick_opcode());
      end else if (pick < 85) begin
        boot(bcai_pkg::FUNC_RESET);
      end else if (pick < 88) begin
        boot(bcai_pkg::FUNC_START);
      end else if (pick < 93) begin
        do op = 8'($urandom_range(0, 255)); while (operand_bytes(op) >= 0);
        send_word(bcai_pkg::FUNC_READ, op);
        repeat ($urandom_range(0, 3)) begin
          send_word(bcai_pkg::FUNC_READ, 8'($urandom_range(0, 255)));
          ignored_words++;
        end
        boot($urandom_range(0, 1) ? bcai_pkg::FUNC_START : bcai_pkg::FUNC_RESET);
      end else if (pick < 96) begin
        send_word(FuncUnused, 8'($urandom_range(0, 255)));
        ignored_words++;
      end else begin
        // Instruction cut short by a warm reset.
        do op = pick_opcode(); while (operand_bytes(op) < 2);
        send_word(bcai_pkg::FUNC_READ, op);
        repeat ($urandom_range(0, operand_bytes(op) - 1)) begin
          send_word(bcai_pkg::FUNC_READ, pick_byte());
        end
        boot(bcai_pkg::FUNC_RESET);
      end
    end

    go_idle();
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
    $display("run covered %0d words (%0d ignored by the core), %0d results compared",
             words_sent, ignored_words, results);
    $display("%0d instructions or vector fetches completed, %0d halts, %0d field mismatches",
             retired, halts, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/bcai_pkg.sv
hw/rtl/bcai_step.sv
hw/rtl/byte_cpu_adc_index_core.sv
hw/rtl/bcai_checker.sv
bench/bcai_core_checker.sv
bench/tb_byte_cpu_adc_index_core.sv
